// ===== sv/skn_pkg.sv =====
package skn_pkg;

   localparam int STATE_WORDS   = 16;
   localparam int ROUND_COUNT   = 80;
   localparam int POSITION_BITS = 32;
   localparam int KEY_WORDS     = STATE_WORDS + 1;
   localparam int FIFO_DEPTH    = 4;

   localparam logic [63:0] KS_PARITY  = 64'h1BD1_1BDA_A9FC_1A22;
   localparam logic [63:0] FLAG_FIRST = 64'h4000_0000_0000_0000;
   localparam logic [63:0] FLAG_FINAL = 64'h8000_0000_0000_0000;
   localparam logic [63:0] TYPE_CFG   = 64'd4 << 56;
   localparam logic [63:0] TYPE_MSG   = 64'd48 << 56;
   localparam logic [63:0] TYPE_OUT   = 64'd63 << 56;
   localparam logic [63:0] CFG_WORD0  = 64'h0000_0001_3341_4853;
   localparam logic [63:0] CFG_WORD1  = 64'd1024;
   localparam logic [63:0] CFG_T0     = 64'd32;
   localparam logic [63:0] OUT_T0     = 64'd8;

   typedef logic [63:0] word_type;
   typedef logic [STATE_WORDS-1:0][63:0] block_type;

   typedef struct packed {
      logic [63:0] word;
      logic [3:0]  count;
      logic        last;
   } entry_type;

   typedef struct packed {
      logic        start;
      logic [63:0] t0;
      logic [63:0] t1;
   } tf_req_type;

   function automatic logic [5:0] rot_amount(input logic [2:0] d, input logic [2:0] i);
      logic [5:0] r;
      r = 6'd0;
      case (d)
         3'd0: case (i)
            3'd0: r = 6'd24; 3'd1: r = 6'd13; 3'd2: r = 6'd8;  3'd3: r = 6'd47;
            3'd4: r = 6'd8;  3'd5: r = 6'd17; 3'd6: r = 6'd22; default: r = 6'd37;
         endcase
         3'd1: case (i)
            3'd0: r = 6'd38; 3'd1: r = 6'd19; 3'd2: r = 6'd10; 3'd3: r = 6'd55;
            3'd4: r = 6'd49; 3'd5: r = 6'd18; 3'd6: r = 6'd23; default: r = 6'd52;
         endcase
         3'd2: case (i)
            3'd0: r = 6'd33; 3'd1: r = 6'd4;  3'd2: r = 6'd51; 3'd3: r = 6'd13;
            3'd4: r = 6'd34; 3'd5: r = 6'd41; 3'd6: r = 6'd59; default: r = 6'd17;
         endcase
         3'd3: case (i)
            3'd0: r = 6'd5;  3'd1: r = 6'd20; 3'd2: r = 6'd48; 3'd3: r = 6'd41;
            3'd4: r = 6'd47; 3'd5: r = 6'd28; 3'd6: r = 6'd16; default: r = 6'd25;
         endcase
         3'd4: case (i)
            3'd0: r = 6'd41; 3'd1: r = 6'd9;  3'd2: r = 6'd37; 3'd3: r = 6'd31;
            3'd4: r = 6'd12; 3'd5: r = 6'd47; 3'd6: r = 6'd44; default: r = 6'd30;
         endcase
         3'd5: case (i)
            3'd0: r = 6'd16; 3'd1: r = 6'd34; 3'd2: r = 6'd56; 3'd3: r = 6'd51;
            3'd4: r = 6'd4;  3'd5: r = 6'd53; 3'd6: r = 6'd42; default: r = 6'd41;
         endcase
         3'd6: case (i)
            3'd0: r = 6'd31; 3'd1: r = 6'd44; 3'd2: r = 6'd47; 3'd3: r = 6'd46;
            3'd4: r = 6'd19; 3'd5: r = 6'd42; 3'd6: r = 6'd44; default: r = 6'd25;
         endcase
         default: case (i)
            3'd0: r = 6'd9;  3'd1: r = 6'd48; 3'd2: r = 6'd35; 3'd3: r = 6'd52;
            3'd4: r = 6'd23; 3'd5: r = 6'd31; 3'd6: r = 6'd37; default: r = 6'd20;
         endcase
      endcase
      return r;
   endfunction

   function automatic logic [3:0] perm_index(input logic [3:0] i);
      logic [3:0] p;
      case (i)
         4'd0: p = 4'd0;   4'd1: p = 4'd9;   4'd2: p = 4'd2;   4'd3: p = 4'd13;
         4'd4: p = 4'd6;   4'd5: p = 4'd11;  4'd6: p = 4'd4;   4'd7: p = 4'd15;
         4'd8: p = 4'd10;  4'd9: p = 4'd7;   4'd10: p = 4'd12; 4'd11: p = 4'd3;
         4'd12: p = 4'd14; 4'd13: p = 4'd5;  4'd14: p = 4'd8;  default: p = 4'd1;
      endcase
      return p;
   endfunction

endpackage

// ===== sv/skn_fifo.sv =====
module skn_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  skn_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output skn_pkg::entry_type  head_entry,
   output logic                head_valid
);

   localparam int AW = $clog2(skn_pkg::FIFO_DEPTH);

   skn_pkg::entry_type mem_ff [skn_pkg::FIFO_DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;

   assign full       = (cnt_ff == (AW+1)'(skn_pkg::FIFO_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_entry = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push && !full) begin
         wr_in = wr_ff + 1'b1;
      end
      if (pop && head_valid) begin
         rd_in = rd_ff + 1'b1;
      end
      cnt_in = cnt_ff + (AW+1)'(push && !full) - (AW+1)'(pop && head_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push && !full) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// ===== sv/skn_front.sv =====
module skn_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [63:0]         in_word,
   input  logic [3:0]          in_count,
   input  logic                in_last,
   input  logic                pop,
   output skn_pkg::entry_type  head_entry,
   output logic                head_valid
);

   skn_pkg::entry_type ent;
   logic               full;
   logic [3:0]         cnt;

   // clamp count to eight, zero the bytes past it
   always_comb begin
      cnt = (in_count > 4'd8) ? 4'd8 : in_count;
      ent.count = cnt;
      ent.last  = in_last;
      for (int b = 0; b < 8; b++) begin
         ent.word[8*b +: 8] = (4'(b) < cnt) ? in_word[8*b +: 8] : 8'h00;
      end
   end

   assign in_ready = !full;

   skn_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (in_valid),
      .push_entry (ent),
      .full       (full),
      .pop        (pop),
      .head_entry (head_entry),
      .head_valid (head_valid)
   );

endmodule

// ===== sv/skn_tf.sv =====
module skn_tf (
   input  logic                 clock,
   input  logic                 reset,
   input  skn_pkg::tf_req_type  req,
   input  skn_pkg::block_type   key,
   input  skn_pkg::block_type   msg,
   output logic                 done,
   output skn_pkg::block_type   result
);

   localparam int NK = skn_pkg::KEY_WORDS;
   localparam int SW = skn_pkg::STATE_WORDS;
   localparam int SB = $clog2(skn_pkg::ROUND_COUNT / 4 + 1);
   localparam int DB = $clog2(skn_pkg::ROUND_COUNT + 1);

   skn_pkg::block_type blk_ff, blk_in, msg_ff, mix;
   logic [NK-1:0][63:0] kx_ff, kx_in;
   logic [2:0][63:0]    tw_ff, tw_in;
   logic [SB-1:0]       s_ff, s_in;
   logic [DB-1:0]       d_ff, d_in;
   logic                busy_ff, busy_in, inj_ff, inj_in, done_ff, done_in;
   logic [63:0]         parity, a, sk;
   logic [5:0]          r;

   assign done   = done_ff;
   assign result = blk_ff ^ msg_ff;

   always_comb begin
      parity = skn_pkg::KS_PARITY;
      for (int i = 0; i < SW; i++) begin
         parity = parity ^ key[i];
      end
      mix = blk_ff;
      for (int i = 0; i < SW / 2; i++) begin
         r = skn_pkg::rot_amount(d_ff[2:0], 3'(i));
         a = blk_ff[2*i] + blk_ff[2*i+1];
         mix[2*i]   = a;
         mix[2*i+1] = ((blk_ff[2*i+1] << r) | (blk_ff[2*i+1] >> (7'd64 - 7'(r)))) ^ a;
      end
   end

   always_comb begin
      blk_in  = blk_ff;
      kx_in   = kx_ff;
      tw_in   = tw_ff;
      s_in    = s_ff;
      d_in    = d_ff;
      busy_in = busy_ff;
      inj_in  = inj_ff;
      done_in = 1'b0;
      sk      = '0;
      if (!busy_ff) begin
         if (req.start) begin
            blk_in  = msg;
            kx_in   = {parity, key};
            tw_in   = {req.t0 ^ req.t1, req.t1, req.t0};
            s_in    = '0;
            d_in    = '0;
            inj_in  = 1'b1;
            busy_in = 1'b1;
         end
      end else if (inj_ff) begin
         // key injection: rotating key and tweak registers give the subkey
         for (int i = 0; i < SW; i++) begin
            sk = kx_ff[i];
            if (i == 13) sk = sk + tw_ff[0];
            if (i == 14) sk = sk + tw_ff[1];
            if (i == 15) sk = sk + 64'(s_ff);
            blk_in[i] = blk_ff[i] + sk;
         end
         for (int j = 0; j < NK; j++) begin
            kx_in[j] = kx_ff[(j + 1) % NK];
         end
         tw_in  = {tw_ff[0], tw_ff[2], tw_ff[1]};
         s_in   = s_ff + 1'b1;
         inj_in = 1'b0;
         if (d_ff == DB'(skn_pkg::ROUND_COUNT)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else begin
         for (int i = 0; i < SW; i++) begin
            blk_in[i] = mix[skn_pkg::perm_index(4'(i))];
         end
         d_in   = d_ff + 1'b1;
         inj_in = (d_in[1:0] == 2'b00) || (d_in == DB'(skn_pkg::ROUND_COUNT));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         inj_ff  <= 1'b0;
         done_ff <= 1'b0;
         s_ff    <= '0;
         d_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         inj_ff  <= inj_in;
         done_ff <= done_in;
         s_ff    <= s_in;
         d_ff    <= d_in;
      end
      blk_ff <= blk_in;
      kx_ff  <= kx_in;
      tw_ff  <= tw_in;
      if (!busy_ff && req.start) begin
         msg_ff <= msg;
      end
   end

endmodule

// ===== sv/skn_back.sv =====
module skn_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  skn_pkg::entry_type  head_entry,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [63:0]         out_word,
   output logic [3:0]          out_index,
   output logic                out_last,
   output logic                out_too_long
);

   localparam int PB = skn_pkg::POSITION_BITS;
   localparam int SW = skn_pkg::STATE_WORDS;
   localparam int WB = $clog2(SW + 1);
   localparam int IB = $clog2(SW);

   localparam logic [3:0] ST_INIT     = 4'd0;
   localparam logic [3:0] ST_CFG_WAIT = 4'd1;
   localparam logic [3:0] ST_IDLE     = 4'd2;
   localparam logic [3:0] ST_BLK_WAIT = 4'd3;
   localparam logic [3:0] ST_STORE    = 4'd4;
   localparam logic [3:0] ST_FIN_GO   = 4'd5;
   localparam logic [3:0] ST_FIN_WAIT = 4'd6;
   localparam logic [3:0] ST_OUT_GO   = 4'd7;
   localparam logic [3:0] ST_OUT_WAIT = 4'd8;
   localparam logic [3:0] ST_EMIT     = 4'd9;

   logic [3:0]          st_ff, st_in;
   skn_pkg::block_type  cv_ff, cv_in, buf_ff, key, msg, tf_result;
   skn_pkg::entry_type  cur_ff;
   logic [WB-1:0]       words_ff, words_in;
   logic [PB-1:0]       pos_ff, pos_in;
   logic [PB:0]         pos_sum;
   logic                first_ff, first_in, ovf_ff, ovf_in, tf_done;
   logic [IB-1:0]       idx_ff, idx_in;
   logic                latch, store;
   skn_pkg::tf_req_type tf_req;

   assign out_valid    = (st_ff == ST_EMIT);
   assign out_word     = cv_ff[idx_ff];
   assign out_index    = 4'(idx_ff);
   assign out_last     = (idx_ff == IB'(SW - 1));
   assign out_too_long = ovf_ff;
   assign pos_sum      = {1'b0, pos_ff} + (PB+1)'(cur_ff.count);

   always_comb begin
      tf_req.start = 1'b0;
      tf_req.t0    = 64'(pos_ff);
      tf_req.t1    = skn_pkg::TYPE_MSG | (first_ff ? skn_pkg::FLAG_FIRST : '0);
      key          = cv_ff;
      msg          = '0;
      for (int i = 0; i < SW; i++) begin
         if (WB'(i) < words_ff) msg[i] = buf_ff[i];
      end
      case (st_ff)
         ST_INIT: begin
            tf_req.start = 1'b1;
            tf_req.t0    = skn_pkg::CFG_T0;
            tf_req.t1    = skn_pkg::TYPE_CFG | skn_pkg::FLAG_FIRST | skn_pkg::FLAG_FINAL;
            key          = '0;
            msg          = '0;
            msg[0]       = skn_pkg::CFG_WORD0;
            msg[1]       = skn_pkg::CFG_WORD1;
         end
         ST_IDLE: begin
            tf_req.start = head_valid && (words_ff >= WB'(SW));
         end
         ST_FIN_GO: begin
            tf_req.start = 1'b1;
            tf_req.t1    = tf_req.t1 | skn_pkg::FLAG_FINAL;
         end
         ST_OUT_GO: begin
            tf_req.start = 1'b1;
            tf_req.t0    = skn_pkg::OUT_T0;
            tf_req.t1    = skn_pkg::TYPE_OUT | skn_pkg::FLAG_FIRST | skn_pkg::FLAG_FINAL;
            msg          = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      st_in    = st_ff;
      cv_in    = cv_ff;
      words_in = words_ff;
      pos_in   = pos_ff;
      first_in = first_ff;
      ovf_in   = ovf_ff;
      idx_in   = idx_ff;
      latch    = 1'b0;
      store    = 1'b0;
      pop      = 1'b0;
      case (st_ff)
         ST_INIT: begin
            st_in = ST_CFG_WAIT;
         end
         ST_CFG_WAIT: begin
            if (tf_done) begin
               cv_in = tf_result;
               st_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head_valid) begin
               pop   = 1'b1;
               latch = 1'b1;
               st_in = (words_ff >= WB'(SW)) ? ST_BLK_WAIT : ST_STORE;
            end
         end
         ST_BLK_WAIT: begin
            if (tf_done) begin
               cv_in    = tf_result;
               first_in = 1'b0;
               words_in = '0;
               st_in    = ST_STORE;
            end
         end
         ST_STORE: begin
            store    = 1'b1;
            words_in = words_ff + 1'b1;
            pos_in   = pos_sum[PB-1:0];
            if (pos_sum[PB]) ovf_in = 1'b1;
            st_in    = cur_ff.last ? ST_FIN_GO : ST_IDLE;
         end
         ST_FIN_GO: begin
            st_in = ST_FIN_WAIT;
         end
         ST_FIN_WAIT: begin
            if (tf_done) begin
               cv_in = tf_result;
               st_in = ST_OUT_GO;
            end
         end
         ST_OUT_GO: begin
            st_in = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (tf_done) begin
               cv_in  = tf_result;
               idx_in = '0;
               st_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_ready) begin
               idx_in = idx_ff + 1'b1;
               if (out_last) begin
                  words_in = '0;
                  pos_in   = '0;
                  first_in = 1'b1;
                  ovf_in   = 1'b0;
                  st_in    = ST_INIT;
               end
            end
         end
         default: begin
            st_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_INIT;
         words_ff <= '0;
         pos_ff   <= '0;
         first_ff <= 1'b1;
         ovf_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         st_ff    <= st_in;
         words_ff <= words_in;
         pos_ff   <= pos_in;
         first_ff <= first_in;
         ovf_ff   <= ovf_in;
         idx_ff   <= idx_in;
      end
      cv_ff <= cv_in;
      if (latch) begin
         cur_ff <= head_entry;
      end
      if (store) begin
         buf_ff[words_ff[IB-1:0]] <= cur_ff.word;
      end
   end

   skn_tf u_tf (
      .clock  (clock),
      .reset  (reset),
      .req    (tf_req),
      .key    (key),
      .msg    (msg),
      .done   (tf_done),
      .result (tf_result)
   );

endmodule

// ===== sv/skn_top_unused_guard.sv =====
module skn_cvt (
   input  logic [71:0] req_data,
   output logic [63:0] word,
   output logic [3:0]  count
);

   // unpack the request payload
   assign word  = req_data[63:0];
   assign count = req_data[67:64];

endmodule

// ===== sv/skein_1024_hash.sv =====
// Skein-1024-1024 hash engine. A message streams in as 64-bit little-endian
// words (first byte in bits 7:0), each with its count of valid bytes; tlast
// marks the final word and messages must be non-empty. After the last word the
// block returns the 1024-bit digest as sixteen transfers, word 0 first, tlast
// on word 15, tuser set if the 32-bit byte position wrapped. Input words go
// through a four-entry queue into an engine that runs one Threefish round or
// one key injection per cycle. A plain word is popped and then stored in the
// back end; a word that opens a new block first waits for the Threefish pass
// over the full block before it. A word that closes a message costs three
// blocks (final, output, and the config pass that restarts the chain), plus
// 16 output transfers. After reset the config pass runs before the first
// word leaves the queue.
module skein_1024_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // message_word[63:0], byte_count[67:64], zero
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // hash_word[63:0], word_index[67:64], zero
   output logic        rsp_tlast,
   output logic        rsp_tuser    // too_long
);

   skn_pkg::entry_type head;
   logic               head_valid, pop;
   logic [63:0]        in_word, hash;
   logic [3:0]         in_count, idx;

   skn_cvt u_cvt (
      .req_data (req_tdata),
      .word     (in_word),
      .count    (in_count)
   );

   skn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_word    (in_word),
      .in_count   (in_count),
      .in_last    (req_tlast),
      .pop        (pop),
      .head_entry (head),
      .head_valid (head_valid)
   );

   skn_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_entry   (head),
      .pop          (pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_word     (hash),
      .out_index    (idx),
      .out_last     (rsp_tlast),
      .out_too_long (rsp_tuser)
   );

   assign rsp_tdata = {4'h0, idx, hash};

endmodule

// ===== verif/skein_1024_hash_tb.sv =====
module skein_1024_hash_tb;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int HOLD_CYCLES    = 400;
   localparam int RANDOM_ITEMS   = 360;

   typedef struct packed {
      logic [63:0] hash;
      logic [3:0]  index;
      logic        last;
      logic        overflow;
   } digest_word_type;

   typedef struct {
      logic [63:0] word;
      logic [3:0]  count;
      logic        last;
   } stim_row_type;

   // rotation constants per round mod 8 and word permutation of Threefish-1024
   localparam int ROT [8][8] = '{
      '{24, 13, 8, 47, 8, 17, 22, 37}, '{38, 19, 10, 55, 49, 18, 23, 52},
      '{33, 4, 51, 13, 34, 41, 59, 17}, '{5, 20, 48, 41, 47, 28, 16, 25},
      '{41, 9, 37, 31, 12, 47, 44, 30}, '{16, 34, 56, 51, 4, 53, 42, 41},
      '{31, 44, 47, 46, 19, 42, 44, 25}, '{9, 48, 35, 52, 23, 31, 37, 20}};
   localparam int PERM [16] = '{0, 9, 2, 13, 6, 11, 4, 15, 10, 7, 12, 3, 14, 5, 8, 1};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;    // message_word[63:0], byte_count[67:64], zero
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;    // hash_word[63:0], word_index[67:64], zero
   logic        rsp_tlast;
   logic        rsp_tuser;    // too_long

   skein_1024_hash uut (.*);

   // predictor state
   skn_pkg::block_type chain;
   skn_pkg::block_type msg_block;
   int          block_fill;
   logic [31:0] byte_pos;
   logic        first_pending;
   logic        pos_wrapped;

   digest_word_type digest_queue[$];
   int  errors;
   int  idle_cycles;
   int  cycle_count;
   bit  sender_calm;
   bit  hold_request;

   initial begin
      clock = 1'b0;
   end
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic skn_pkg::block_type threefish(skn_pkg::block_type key,
                                                    skn_pkg::word_type t0,
                                                    skn_pkg::word_type t1,
                                                    skn_pkg::block_type data);
      skn_pkg::word_type  kx [17];
      skn_pkg::word_type  tw [3];
      skn_pkg::block_type mixed;
      skn_pkg::word_type  sum, sub, y;
      int                 s;
      kx[16] = skn_pkg::KS_PARITY;
      for (int i = 0; i < 16; i++) begin
         kx[i] = key[i];
         kx[16] = kx[16] ^ key[i];
      end
      tw[0] = t0;
      tw[1] = t1;
      tw[2] = t0 ^ t1;
      for (int d = 0; d <= skn_pkg::ROUND_COUNT; d++) begin
         if (d % 4 == 0) begin
            s = d / 4;
            for (int i = 0; i < 16; i++) begin
               sub = kx[(s + i) % 17];
               if (i == 13) sub = sub + tw[s % 3];
               if (i == 14) sub = sub + tw[(s + 1) % 3];
               if (i == 15) sub = sub + skn_pkg::word_type'(s);
               data[i] = data[i] + sub;
            end
         end
         if (d == skn_pkg::ROUND_COUNT) break;
         for (int i = 0; i < 8; i++) begin
            sum = data[2*i] + data[2*i+1];
            y   = data[2*i+1];
            y   = (y << ROT[d % 8][i]) | (y >> (64 - ROT[d % 8][i]));
            data[2*i+1] = y ^ sum;
            data[2*i]   = sum;
         end
         for (int i = 0; i < 16; i++) mixed[i] = data[PERM[i]];
         data = mixed;
      end
      return data;
   endfunction

   function automatic skn_pkg::block_type ubi(skn_pkg::block_type g, skn_pkg::block_type m,
                                              skn_pkg::word_type t0, skn_pkg::word_type t1);
      return threefish(g, t0, t1, m) ^ m;
   endfunction

   task automatic restart_chain();
      skn_pkg::block_type cfg;
      cfg = '0;
      cfg[0] = skn_pkg::CFG_WORD0;
      cfg[1] = skn_pkg::CFG_WORD1;
      chain = ubi('0, cfg, skn_pkg::CFG_T0,
                  skn_pkg::TYPE_CFG | skn_pkg::FLAG_FIRST | skn_pkg::FLAG_FINAL);
      msg_block = '0;
      block_fill = 0;
      byte_pos = '0;
      first_pending = 1'b1;
      pos_wrapped = 1'b0;
   endtask

   task automatic absorb_word(logic [63:0] word, logic [3:0] count, logic last);
      int          n;
      logic [32:0] next_pos;
      digest_word_type dw;
      n = (count > 8) ? 8 : count;
      if (n < 8) word = word & ((64'd1 << (8 * n)) - 64'd1);
      if (block_fill >= skn_pkg::STATE_WORDS) begin
         chain = ubi(chain, msg_block, {32'd0, byte_pos},
                     skn_pkg::TYPE_MSG | (first_pending ? skn_pkg::FLAG_FIRST : 64'd0));
         first_pending = 1'b0;
         block_fill = 0;
      end
      msg_block[block_fill] = word;
      block_fill++;
      next_pos = {1'b0, byte_pos} + 33'(n);
      if (next_pos[32]) pos_wrapped = 1'b1;
      byte_pos = next_pos[31:0];
      if (last) begin
         for (int i = block_fill; i < 16; i++) msg_block[i] = '0;
         chain = ubi(chain, msg_block, {32'd0, byte_pos},
                     skn_pkg::TYPE_MSG | skn_pkg::FLAG_FINAL |
                     (first_pending ? skn_pkg::FLAG_FIRST : 64'd0));
         chain = ubi(chain, '0, skn_pkg::OUT_T0,
                     skn_pkg::TYPE_OUT | skn_pkg::FLAG_FIRST | skn_pkg::FLAG_FINAL);
         for (int i = 0; i < 16; i++) begin
            dw.hash = chain[i];
            dw.index = 4'(i);
            dw.last = (i == 15);
            dw.overflow = pos_wrapped;
            digest_queue.push_back(dw);
         end
         restart_chain();
      end
   endtask

   // one transfer on the request side; valid stays high into the next item
   task automatic send_word(logic [63:0] word, logic [3:0] count, logic last);
      if (!sender_calm && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, count, word};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      absorb_word(word, count, last);
   endtask

   function automatic logic [63:0] rand_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // receiver: random stalls, a quiet stretch, and one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            hold_request = 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (cycle_count > 3000 && cycle_count < 9000)
            rsp_tready <= 1'b1;
         else
            rsp_tready <= ($urandom_range(99) >= 16);
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (rsp_tvalid && rsp_tready) begin
         if (digest_queue.size() == 0) begin
            $display("%0t: unexpected digest transfer %h", $time, rsp_tdata);
            errors++;
         end else begin
            digest_word_type want;
            want = digest_queue.pop_front();
            if (rsp_tdata[63:0] !== want.hash || rsp_tdata[67:64] !== want.index ||
                rsp_tdata[71:68] !== 4'd0 || rsp_tlast !== want.last ||
                rsp_tuser !== want.overflow) begin
               $display("%0t: mismatch expected hash %h idx %0d last %b ovf %b",
                        $time, want.hash, want.index, want.last, want.overflow);
               $display("%0t:          actual   hash %h idx %0d last %b ovf %b",
                        $time, rsp_tdata[63:0], rsp_tdata[67:64], rsp_tlast, rsp_tuser);
               errors++;
            end
         end
      end
      if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      stim_row_type rows [$];
      int          sent;
      int          len;
      logic [3:0]  cnt;
      errors = 0;
      idle_cycles = 0;
      cycle_count = 0;
      sender_calm = 1'b0;
      hold_request = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      restart_chain();
      // single-word messages at the field extremes, count zero, count above eight,
      // a short word that is not last, then a message ending on a block edge
      rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1});
      rows.push_back('{64'h0, 4'd8, 1'b1});
      rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1});
      rows.push_back('{64'h0123_4567_89AB_CDEF, 4'd0, 1'b1});
      rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1});
      rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd3, 1'b0});
      rows.push_back('{64'hA5A5_5A5A_F00F_0FF0, 4'd7, 1'b1});
      for (int i = 0; i < 16; i++)
         rows.push_back('{{32'hC0DE_0000 + i, 32'h1357_9BDF}, 4'd8, i == 15});
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (rows[i]) send_word(rows[i].word, rows[i].count, rows[i].last);
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         len = ($urandom_range(9) < 8) ? $urandom_range(1, 18) : $urandom_range(19, 40);
         for (int k = 0; k < len; k++) begin
            if (k == len - 1)
               cnt = ($urandom_range(3) == 0) ? 4'd8 : 4'($urandom_range(15));
            else
               cnt = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'd8;
            sender_calm = (sent > 150 && sent < 230);
            if (sent == 60) hold_request = 1'b1;
            send_word(rand_word(), cnt, k == len - 1);
            sent++;
         end
      end
      req_tvalid <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
